// ===== hdl/tbp_pkg.sv =====
// Package for the tournament branch predictor: sizes, mode codes, item
// structs and the counter/history update functions.
// No dependencies.
`default_nettype none

package tbp_pkg;

  localparam int INDEX_BITS          = 10;
  localparam int LOCAL_HISTORY_COUNT = 128;
  localparam int TABLE_SIZE          = 1 << INDEX_BITS;
  localparam int LHS_BITS            = $clog2(LOCAL_HISTORY_COUNT);
  // the clear sweep covers the larger of the two address spaces
  localparam int CLR_BITS            = (INDEX_BITS > LHS_BITS) ? INDEX_BITS : LHS_BITS;
  localparam int CTR_BITS            = 2;
  localparam logic [CTR_BITS-1:0] CTR_INIT = 2'd3;

  typedef enum logic [1:0] {
    MODE_TAKEN      = 2'd0,
    MODE_LOCAL      = 2'd1,
    MODE_GSHARE     = 2'd2,
    MODE_TOURNAMENT = 2'd3
  } mode_e;

  typedef struct packed {
    logic [31:0] pc;
    logic        taken;
  } in_t;

  typedef struct packed {
    logic predicted_taken;
    logic local_prediction;
    logic gshare_prediction;
    logic chose_gshare;
  } out_t;

  typedef struct packed {
    logic [CTR_BITS-1:0] lctr;
    logic [CTR_BITS-1:0] gctr;
    logic [CTR_BITS-1:0] cctr;
  } train_t;

  typedef struct packed {
    logic                active;
    logic [CLR_BITS-1:0] addr;
  } clr_t;

  function automatic logic [CTR_BITS-1:0] sat_toward(input logic [CTR_BITS-1:0] c,
                                                     input logic up);
    logic [CTR_BITS-1:0] r;
    if (up) begin
      r = (c == '1) ? c : c + 1'b1;
    end else begin
      r = (c == '0) ? c : c - 1'b1;
    end
    return r;
  endfunction

  function automatic logic [INDEX_BITS-1:0] shift_in(input logic [INDEX_BITS-1:0] h,
                                                     input logic t);
    return {h[INDEX_BITS-2:0], t};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tbp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read-first: a write at the same edge is not seen
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/tbp_init.sv =====
// Post-reset clear sequencer: sweeps each address of the CLR_BITS space once.
// Depends on tbp_pkg.
`default_nettype none

module tbp_init (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  output tbp_pkg::clr_t      clr_o
);

  logic                         active_q, active_d;
  logic [tbp_pkg::CLR_BITS-1:0] cnt_q, cnt_d;

  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    if (active_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == '1) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b1;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
    end
  end

  assign clr_o.active = active_q;
  assign clr_o.addr   = cnt_q;

endmodule

`default_nettype wire

// ===== hdl/tbp_train.sv =====
// Prediction select and training update for one branch item.
// Depends on tbp_pkg.
`default_nettype none

module tbp_train (
  input  wire logic [tbp_pkg::CTR_BITS-1:0] lctr_i,
  input  wire logic [tbp_pkg::CTR_BITS-1:0] gctr_i,
  input  wire logic [tbp_pkg::CTR_BITS-1:0] cctr_i,
  input  wire logic                         taken_i,
  input  tbp_pkg::mode_e                    mode_i,
  output tbp_pkg::out_t                     res_o,
  output tbp_pkg::train_t                   upd_o
);

  logic lpred, gpred, chose_g, pred;

  assign lpred   = lctr_i[tbp_pkg::CTR_BITS-1];
  assign gpred   = gctr_i[tbp_pkg::CTR_BITS-1];
  assign chose_g = cctr_i[tbp_pkg::CTR_BITS-1];

  always_comb begin
    unique case (mode_i)
      tbp_pkg::MODE_TAKEN:      pred = 1'b1;
      tbp_pkg::MODE_LOCAL:      pred = lpred;
      tbp_pkg::MODE_GSHARE:     pred = gpred;
      tbp_pkg::MODE_TOURNAMENT: pred = chose_g ? gpred : lpred;
      default:                  pred = 1'b1;
    endcase
  end

  assign res_o.predicted_taken   = pred;
  assign res_o.local_prediction  = lpred;
  assign res_o.gshare_prediction = gpred;
  assign res_o.chose_gshare      = chose_g;

  assign upd_o.lctr = tbp_pkg::sat_toward(lctr_i, taken_i);
  assign upd_o.gctr = tbp_pkg::sat_toward(gctr_i, taken_i);

  // chooser moves toward whichever part alone was right
  always_comb begin
    priority if ((lpred == taken_i) && (gpred != taken_i)) begin
      upd_o.cctr = tbp_pkg::sat_toward(cctr_i, 1'b0);
    end else if ((gpred == taken_i) && (lpred != taken_i)) begin
      upd_o.cctr = tbp_pkg::sat_toward(cctr_i, 1'b1);
    end else begin
      upd_o.cctr = cctr_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tournament_branch_predictor.sv =====
// Tournament branch predictor (local history + gshare, per-address chooser).
// One item per cycle sustained while the output is not stalled. Stage 1 holds
// the local history read from the history RAM, stage 2 the three counter RAM
// reads (local index comes from that history), then the result register.
// Each RAM is written as its stage retires, and an item entering a stage
// picks up the write made at that same edge through a one-deep bypass, so
// back-to-back branches to the same entry train correctly. Global history
// is updated as the item is accepted. After reset a clear pass over
// 2^max(INDEX_BITS, log2 LOCAL_HISTORY_COUNT) addresses (1024 here) fills
// the tables; input stays stalled meanwhile, mode writes are taken at any time.
// Depends on tbp_pkg, tbp_ram, tbp_init, tbp_train.
`default_nettype none

module tournament_branch_predictor (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_data_i,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  tbp_pkg::in_t       in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output tbp_pkg::out_t      out_data_o
);

  localparam int IB = tbp_pkg::INDEX_BITS;
  localparam int LB = tbp_pkg::LHS_BITS;
  localparam int CB = tbp_pkg::CTR_BITS;

  tbp_pkg::clr_t   clr;
  tbp_pkg::mode_e  mode_q;
  logic [IB-1:0]   ghr_q;

  logic adv_o, adv2, adv1, in_acc;

  // stage 1
  logic          v1_q;
  logic [LB-1:0] s1_lsel_q;
  logic          s1_taken_q;
  logic [IB-1:0] s1_gidx_q, s1_cidx_q;
  logic          h_fwd_q, h_fwd_d;
  logic [IB-1:0] h_fwd_val_q;
  logic [IB-1:0] hist_rdata, hist1, hist_new;
  logic          hist_we;

  // stage 2
  logic          v2_q;
  logic          s2_taken_q;
  logic [IB-1:0] s2_lidx_q, s2_gidx_q, s2_cidx_q;
  logic          l_fwd_q, g_fwd_q, c_fwd_q;
  logic          l_fwd_d, g_fwd_d, c_fwd_d;
  logic [CB-1:0] l_fwd_val_q, g_fwd_val_q, c_fwd_val_q;
  logic [CB-1:0] l_rdata, g_rdata, c_rdata;
  logic [CB-1:0] l_ctr, g_ctr, c_ctr;
  logic          ctr_we;
  tbp_pkg::out_t   res;
  tbp_pkg::train_t upd;

  // result register
  logic          vo_q;
  tbp_pkg::out_t out_q;

  // RAM write ports
  logic          hram_we, lram_we, gram_we, cram_we;
  logic [LB-1:0] hram_waddr;
  logic [IB-1:0] hram_wdata;
  logic [IB-1:0] lram_waddr, gram_waddr, cram_waddr;
  logic [CB-1:0] lram_wdata, gram_wdata, cram_wdata;

  tbp_init u_init (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_o  (clr)
  );

  // ---- handshake ----
  assign adv_o      = !vo_q || !out_stall_i;
  assign adv2       = !v2_q || adv_o;
  assign adv1       = !v1_q || adv2;
  assign in_stall_o = clr.active || !adv1;
  assign in_acc     = in_valid_i && !in_stall_o;

  // ---- mode and global history ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= tbp_pkg::MODE_TOURNAMENT;
    end else if (cfg_we_i) begin
      mode_q <= tbp_pkg::mode_e'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ghr_q <= '0;
    end else if (in_acc) begin
      ghr_q <= tbp_pkg::shift_in(ghr_q, in_data_i.taken);
    end
  end

  // ---- stage 1: local history ----
  assign hist1    = h_fwd_q ? h_fwd_val_q : hist_rdata;
  assign hist_new = tbp_pkg::shift_in(hist1, s1_taken_q);
  assign hist_we  = v1_q && adv2;
  assign h_fwd_d  = hist_we && (s1_lsel_q == in_data_i.pc[LB-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv1) begin
      v1_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_lsel_q   <= in_data_i.pc[LB-1:0];
      s1_taken_q  <= in_data_i.taken;
      s1_gidx_q   <= in_data_i.pc[IB-1:0] ^ ghr_q;
      s1_cidx_q   <= in_data_i.pc[IB-1:0];
      h_fwd_q     <= h_fwd_d;
      h_fwd_val_q <= hist_new;
    end
  end

  // ---- stage 2: counters ----
  assign l_ctr  = l_fwd_q ? l_fwd_val_q : l_rdata;
  assign g_ctr  = g_fwd_q ? g_fwd_val_q : g_rdata;
  assign c_ctr  = c_fwd_q ? c_fwd_val_q : c_rdata;
  assign ctr_we = v2_q && adv_o;

  assign l_fwd_d = ctr_we && (s2_lidx_q == hist1);
  assign g_fwd_d = ctr_we && (s2_gidx_q == s1_gidx_q);
  assign c_fwd_d = ctr_we && (s2_cidx_q == s1_cidx_q);

  tbp_train u_train (
    .lctr_i  (l_ctr),
    .gctr_i  (g_ctr),
    .cctr_i  (c_ctr),
    .taken_i (s2_taken_q),
    .mode_i  (mode_q),
    .res_o   (res),
    .upd_o   (upd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      s2_taken_q  <= s1_taken_q;
      s2_lidx_q   <= hist1;
      s2_gidx_q   <= s1_gidx_q;
      s2_cidx_q   <= s1_cidx_q;
      l_fwd_q     <= l_fwd_d;
      g_fwd_q     <= g_fwd_d;
      c_fwd_q     <= c_fwd_d;
      l_fwd_val_q <= upd.lctr;
      g_fwd_val_q <= upd.gctr;
      c_fwd_val_q <= upd.cctr;
    end
  end

  // ---- result register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (adv_o) begin
      vo_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      out_q <= res;
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

  // ---- memories, shared with the clear sweep ----
  assign hram_we    = clr.active || hist_we;
  assign hram_waddr = clr.active ? clr.addr[LB-1:0] : s1_lsel_q;
  assign hram_wdata = clr.active ? '0 : hist_new;

  assign lram_we    = clr.active || ctr_we;
  assign gram_we    = clr.active || ctr_we;
  assign cram_we    = clr.active || ctr_we;
  assign lram_waddr = clr.active ? clr.addr[IB-1:0] : s2_lidx_q;
  assign gram_waddr = clr.active ? clr.addr[IB-1:0] : s2_gidx_q;
  assign cram_waddr = clr.active ? clr.addr[IB-1:0] : s2_cidx_q;
  assign lram_wdata = clr.active ? tbp_pkg::CTR_INIT : upd.lctr;
  assign gram_wdata = clr.active ? tbp_pkg::CTR_INIT : upd.gctr;
  assign cram_wdata = clr.active ? tbp_pkg::CTR_INIT : upd.cctr;

  tbp_ram #(.WIDTH(IB), .DEPTH(tbp_pkg::LOCAL_HISTORY_COUNT)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hram_we),
    .waddr_i (hram_waddr),
    .wdata_i (hram_wdata),
    .re_i    (adv1),
    .raddr_i (in_data_i.pc[LB-1:0]),
    .rdata_o (hist_rdata)
  );

  tbp_ram #(.WIDTH(CB), .DEPTH(tbp_pkg::TABLE_SIZE)) u_local_ram (
    .clk_i   (clk_i),
    .we_i    (lram_we),
    .waddr_i (lram_waddr),
    .wdata_i (lram_wdata),
    .re_i    (adv2),
    .raddr_i (hist1),
    .rdata_o (l_rdata)
  );

  tbp_ram #(.WIDTH(CB), .DEPTH(tbp_pkg::TABLE_SIZE)) u_gshare_ram (
    .clk_i   (clk_i),
    .we_i    (gram_we),
    .waddr_i (gram_waddr),
    .wdata_i (gram_wdata),
    .re_i    (adv2),
    .raddr_i (s1_gidx_q),
    .rdata_o (g_rdata)
  );

  tbp_ram #(.WIDTH(CB), .DEPTH(tbp_pkg::TABLE_SIZE)) u_chooser_ram (
    .clk_i   (clk_i),
    .we_i    (cram_we),
    .waddr_i (cram_waddr),
    .wdata_i (cram_wdata),
    .re_i    (adv2),
    .raddr_i (s1_cidx_q),
    .rdata_o (c_rdata)
  );

  // ---- assertions ----
  a_no_train_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr.active |-> !(hist_we || ctr_we || v1_q || v2_q || vo_q))
    else $error("training or items in flight during clear sweep");

  a_stage2_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !adv_o) |=> v2_q)
    else $error("stage 2 item lost while output stalled");

  a_ghr_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(ghr_q))
    else $error("global history changed without an accepted item");

  a_ctr_write_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctr_we |=> vo_q)
    else $error("counter training without a result item");

endmodule

`default_nettype wire
